// ===== rtl/mpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpd_pkg
// shared types and constants for the min partition difference core
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int DEF_MAX_ITEMS   = 16;
  localparam int DEF_WEIGHT_BITS = 30;

  // fixed field widths of the two channels
  localparam int IN_WEIGHT_W = 30;
  localparam int OUT_DIFF_W  = 34;
  localparam logic [OUT_DIFF_W-1:0] OUT_DIFF_MAX = '1;

  // entries of the queue between front and back, power of two
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [IN_WEIGHT_W-1:0] weight;
    logic                   last_weight;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_DIFF_W-1:0] min_difference;
    logic                  overflow;
  } out_beat_t;

  // classified item handed from front to back
  typedef struct packed {
    in_beat_t beat;
    logic     keep;   // weight goes into the store
    logic     ovf;    // a weight of this set was dropped so far
  } token_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SEARCH,
    B_DONE
  } back_state_t;

endpackage

// ===== rtl/min_partition_difference_core.sv =====
// ----------------------------------------------------------------------------
// min_partition_difference_core
// smallest two-way split difference of a weight set, exhaustive gray-code walk
// ----------------------------------------------------------------------------
// result path: the last weight beat of an N-weight set goes through the queue hop,
//   the search over all 2^N subsets and the done state before the result shows
// throughput: weight beats move at one per cycle while the back end loads; a set
//   then holds the back end during its search, the queue fills and full stalls
// reset: synchronous, active low; clears counters, queue and result valid flag,
//   the weight store is left as is and only read after being written
// ----------------------------------------------------------------------------
module min_partition_difference_core import mpd_pkg::*; #(
  parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  // weight beats
  input  logic      push,
  output logic      full,
  input  in_beat_t  in_data,
  // result beats
  output logic      empty,
  input  logic      pop,
  output out_beat_t out_data
);

  // front to queue
  logic   fq_wr;
  token_t fq_token;
  logic   fq_full;

  // queue to back
  logic   qb_rd;
  token_t qb_token;
  logic   qb_empty;

  // back to result register
  logic      res_valid;
  out_beat_t res_data;
  logic      res_ready;

  // output register keeps the result while the back end takes the next set
  logic      out_valid_r;
  out_beat_t out_data_r;

  // front: accept beats, count and mark dropped weights
  mpd_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .q_full  (fq_full),
    .full    (full),
    .q_wr    (fq_wr),
    .q_token (fq_token)
  );

  // decoupling queue so the front can take beats during a search until it fills
  mpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_wr),
    .wr_data (fq_token),
    .full    (fq_full),
    .rd_en   (qb_rd),
    .rd_data (qb_token),
    .empty   (qb_empty)
  );

  // back: weight store and subset search
  mpd_back #(
    .MAX_ITEMS   (MAX_ITEMS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (qb_empty),
    .q_token   (qb_token),
    .q_rd      (qb_rd),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready)
  );

  // register is free when empty or being popped this cycle
  assign res_ready = !out_valid_r || pop;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign empty    = !out_valid_r;
  assign out_data = out_data_r;

endmodule

// ===== rtl/mpd_front.sv =====
// ----------------------------------------------------------------------------
// mpd_front
// accepts weights, tracks fill level and drop status of the current set
// ----------------------------------------------------------------------------
module mpd_front import mpd_pkg::*; #(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_beat_t in_data,
  input  logic     q_full,
  output logic     full,
  output logic     q_wr,
  output token_t   q_token
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             keep;

  assign full = q_full;
  assign q_wr = push && !q_full;
  assign keep = cnt_r < CNT_W'(MAX_ITEMS);

  assign q_token.beat = in_data;
  assign q_token.keep = keep;
  assign q_token.ovf  = ovf_r || !keep;

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (q_wr) begin
      if (in_data.last_weight) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (keep) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// ===== rtl/mpd_fifo.sv =====
// ----------------------------------------------------------------------------
// mpd_fifo
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module mpd_fifo import mpd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  token_t wr_data,
  output logic   full,
  input  logic   rd_en,
  output token_t rd_data,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/mpd_back.sv =====
// ----------------------------------------------------------------------------
// mpd_back
// weight store and gray-code subset search, one subset per cycle
// ----------------------------------------------------------------------------
module mpd_back import mpd_pkg::*; #(
  parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  token_t    q_token,
  output logic      q_rd,
  output logic      res_valid,
  output out_beat_t res_data,
  input  logic      res_ready
);

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int SUM_W  = WEIGHT_BITS + $clog2(MAX_ITEMS + 1);
  localparam int RUN_W  = SUM_W + 1;
  localparam int STEP_W = MAX_ITEMS + 1;
  localparam int EXT_W  = (SUM_W > OUT_DIFF_W) ? SUM_W : OUT_DIFF_W;

  logic [WEIGHT_BITS-1:0] store [MAX_ITEMS];

  back_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]  best_r, best_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [MAX_ITEMS-1:0] members_r, members_nxt;
  logic              cmp_valid_r, cmp_valid_nxt;
  logic              ovf_r, ovf_nxt;

  logic                   upd_en;
  logic                   start;
  logic [WEIGHT_BITS-1:0] w_in;
  logic [SUM_W-1:0]       set_sum;
  logic [STEP_W-1:0]      step_lim;
  logic                   step_end;
  logic [IDX_W-1:0]       flip_idx;
  logic [WEIGHT_BITS-1:0] flip_w;
  logic [RUN_W-1:0]       flip_w2;
  logic [RUN_W-1:0]       run_neg;
  logic [SUM_W-1:0]       run_abs;
  logic [EXT_W-1:0]       best_ext;

  assign w_in     = WEIGHT_BITS'(q_token.beat.weight);
  assign step_lim = STEP_W'(1) << n_r;
  assign step_end = step_r == step_lim;
  assign start    = q_rd && q_token.beat.last_weight;

  // lowest set bit of the step count picks the weight that moves
  always_comb begin
    flip_idx = '0;
    for (int i = MAX_ITEMS - 1; i >= 0; i--) begin
      if (step_r[i]) begin
        flip_idx = IDX_W'(i);
      end
    end
  end

  assign flip_w  = store[flip_idx];
  assign flip_w2 = RUN_W'({flip_w, 1'b0});
  assign run_neg = -run_r;
  assign run_abs = run_r[RUN_W-1] ? run_neg[SUM_W-1:0] : run_r[SUM_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (start) begin
          state_nxt = B_SEARCH;
        end
      end
      B_SEARCH: begin
        if (step_end) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (res_ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_rd      = 1'b0;
    upd_en    = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      B_IDLE:   q_rd      = !q_empty;
      B_SEARCH: upd_en    = !step_end;
      B_DONE:   res_valid = 1'b1;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    wr_idx_nxt    = wr_idx_r;
    n_nxt         = n_r;
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    run_nxt       = run_r;
    step_nxt      = step_r;
    members_nxt   = members_r;
    ovf_nxt       = ovf_r;
    cmp_valid_nxt = upd_en;
    set_sum       = sum_r + (q_token.keep ? SUM_W'(w_in) : '0);

    if (q_rd) begin
      if (q_token.beat.last_weight) begin
        n_nxt       = wr_idx_r + (q_token.keep ? CNT_W'(1) : '0);
        run_nxt     = -RUN_W'(set_sum);
        best_nxt    = set_sum;
        step_nxt    = STEP_W'(1);
        members_nxt = '0;
        ovf_nxt     = q_token.ovf;
        sum_nxt     = '0;
        wr_idx_nxt  = '0;
      end else begin
        sum_nxt = set_sum;
        if (q_token.keep) begin
          wr_idx_nxt = wr_idx_r + CNT_W'(1);
        end
      end
    end

    if (upd_en) begin
      members_nxt[flip_idx] = !members_r[flip_idx];
      run_nxt  = members_r[flip_idx] ? run_r - flip_w2 : run_r + flip_w2;
      step_nxt = step_r + STEP_W'(1);
    end

    // compare uses the running difference in the cycle after it is updated
    if (cmp_valid_r && run_abs < best_r) begin
      best_nxt = run_abs;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd && q_token.keep) begin
      store[wr_idx_r[IDX_W-1:0]] <= w_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      wr_idx_r    <= '0;
      n_r         <= '0;
      sum_r       <= '0;
      best_r      <= '1;
      run_r       <= '0;
      step_r      <= '0;
      members_r   <= '0;
      cmp_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      n_r         <= n_nxt;
      sum_r       <= sum_nxt;
      best_r      <= best_nxt;
      run_r       <= run_nxt;
      step_r      <= step_nxt;
      members_r   <= members_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // saturate to the result field
  assign best_ext = EXT_W'(best_r);
  assign res_data.min_difference = (best_ext > EXT_W'(OUT_DIFF_MAX)) ?
                                   OUT_DIFF_MAX : best_ext[OUT_DIFF_W-1:0];
  assign res_data.overflow = ovf_r;

endmodule
